[src/implicit_cylinder_evaluator_core_assert.svh]
// Assertion macros for the implicit cylinder evaluator
`ifndef IMPLICIT_CYLINDER_EVALUATOR_CORE_ASSERT_SVH
`define IMPLICIT_CYLINDER_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define ICE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ICE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ice_pkg.sv]
// Package: types, widths and register map of the implicit cylinder evaluator
`timescale 1ns / 1ps
`default_nettype none
package ice_pkg;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int NUM_W  = 168;
    localparam int DEN_W  = 128;
    localparam int QUO_W  = 48;
    localparam int REM_W  = DEN_W + 1;

    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_AXIS   = 3'd1;
    localparam logic [2:0] REG_CENTER = 3'd2;
    localparam logic [2:0] REG_MODE   = 3'd3;
    localparam logic [2:0] REG_ELLV   = 3'd4;
    localparam logic [2:0] REG_RATIO  = 3'd5;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [47:0] field_value;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        logic [47:0]        axis;
        logic [47:0]        center;
        logic [47:0]        ellv;
        logic               ellip;
        logic [31:0]        rsq;
        logic [31:0]        a2;
        logic signed [32:0] w0;
        logic signed [32:0] w1;
        logic signed [32:0] w2;
        logic signed [32:0] ae;
        logic [31:0]        rr2;
        logic               deg;
        logic [DEN_W-1:0]   den;
    } t_geom;

    function automatic logic signed [15:0] half(input logic [47:0] v, input logic [1:0] idx);
        return $signed(v[16*idx +: 16]);
    endfunction

endpackage
`default_nettype wire

[src/ice_cfg.sv]
// Configuration registers and geometry precompute chain
`timescale 1ns / 1ps
`default_nettype none
module ice_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ice_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ice_pkg::DATA_W-1:0] pwdata,
    output logic      [ice_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output ice_pkg::t_geom                 o_geom
);
    logic [15:0] r_radius;
    logic [47:0] r_axis;
    logic [47:0] r_center;
    logic        r_ellip;
    logic [47:0] r_ellv;
    logic [15:0] r_ratio;

    logic signed [15:0] w_a [0:2];
    logic signed [15:0] w_e [0:2];

    logic signed [31:0] r1_aa [0:2];
    logic signed [31:0] r1_p  [0:5];
    logic signed [31:0] r1_ae [0:2];
    logic [31:0]        r1_rsq;
    logic [31:0]        r1_rr2;
    logic [31:0]        r2_a2;
    logic signed [32:0] r2_w  [0:2];
    logic signed [32:0] r2_ae;
    logic [63:0]        r3_sq [0:2];
    logic               r3_deg;
    logic [63:0]        r4_w2;
    logic [63:0]        r5_ml;
    logic [63:0]        r5_mh;
    logic [95:0]        r6_wa;
    logic [63:0]        r7_k  [0:2];
    logic [ice_pkg::DEN_W-1:0] r8_den;

    logic signed [32:0] n_wabs [0:2];
    logic               w_wr;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 16'd16;
            r_axis   <= 48'h4000_0000_0000;
            r_center <= '0;
            r_ellip  <= 1'b0;
            r_ellv   <= 48'h0000_0000_4000;
            r_ratio  <= 16'd8192;
        end else if (w_wr) begin
            unique case (paddr[5:3])
                ice_pkg::REG_RADIUS: r_radius <= pwdata[15:0];
                ice_pkg::REG_AXIS:   r_axis   <= pwdata[47:0];
                ice_pkg::REG_CENTER: r_center <= pwdata[47:0];
                ice_pkg::REG_MODE:   r_ellip  <= pwdata[0];
                ice_pkg::REG_ELLV:   r_ellv   <= pwdata[47:0];
                ice_pkg::REG_RATIO:  r_ratio  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            ice_pkg::REG_RADIUS: prdata = {48'd0, r_radius};
            ice_pkg::REG_AXIS:   prdata = {16'd0, r_axis};
            ice_pkg::REG_CENTER: prdata = {16'd0, r_center};
            ice_pkg::REG_MODE:   prdata = {63'd0, r_ellip};
            ice_pkg::REG_ELLV:   prdata = {16'd0, r_ellv};
            ice_pkg::REG_RATIO:  prdata = {48'd0, r_ratio};
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i]    = ice_pkg::half(r_axis, 2'(i));
            w_e[i]    = ice_pkg::half(r_ellv, 2'(i));
            n_wabs[i] = r2_w[i][32] ? -r2_w[i] : r2_w[i];
        end
    end

    // free-running; user keeps registers static in flight; not enforced
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_aa[i] <= w_a[i] * w_a[i];
            r1_ae[i] <= w_a[i] * w_e[i];
        end
        r1_p[0] <= w_a[1] * w_e[2];
        r1_p[1] <= w_a[2] * w_e[1];
        r1_p[2] <= w_a[2] * w_e[0];
        r1_p[3] <= w_a[0] * w_e[2];
        r1_p[4] <= w_a[0] * w_e[1];
        r1_p[5] <= w_a[1] * w_e[0];
        r1_rsq  <= 32'(r_radius) * 32'(r_radius);
        r1_rr2  <= 32'(r_ratio) * 32'(r_ratio);

        r2_a2 <= 32'(r1_aa[0]) + 32'(r1_aa[1]) + 32'(r1_aa[2]);
        for (int k = 0; k < 3; k++) begin
            r2_w[k] <= 33'(r1_p[2*k]) - 33'(r1_p[2*k+1]);
        end
        r2_ae <= 33'(r1_ae[0]) + 33'(r1_ae[1]) + 33'(r1_ae[2]);

        for (int k = 0; k < 3; k++) begin
            r3_sq[k] <= 64'(n_wabs[k][31:0]) * 64'(n_wabs[k][31:0]);
        end
        r3_deg <= (r2_a2 == '0) ||
                  (r_ellip && (((r2_w[0] == '0) && (r2_w[1] == '0) && (r2_w[2] == '0)) ||
                               (r_ratio == '0)));

        r4_w2 <= r3_sq[0] + r3_sq[1] + r3_sq[2];

        r5_ml <= 64'(r4_w2[31:0]) * 64'(r2_a2);
        r5_mh <= 64'(r4_w2[63:32]) * 64'(r2_a2);

        r6_wa <= 96'(r5_ml) + (96'(r5_mh) << 32);

        for (int k = 0; k < 3; k++) begin
            r7_k[k] <= 64'(r6_wa[32*k +: 32]) * 64'(r1_rr2);
        end

        r8_den <= r_ellip ? (128'(r7_k[0]) + (128'(r7_k[1]) << 32) + (128'(r7_k[2]) << 64))
                          : 128'(r2_a2);
    end

    always_comb begin
        o_geom        = '0;
        o_geom.axis   = r_axis;
        o_geom.center = r_center;
        o_geom.ellv   = r_ellv;
        o_geom.ellip  = r_ellip;
        o_geom.rsq    = r1_rsq;
        o_geom.a2     = r2_a2;
        o_geom.w0     = r2_w[0];
        o_geom.w1     = r2_w[1];
        o_geom.w2     = r2_w[2];
        o_geom.ae     = r2_ae;
        o_geom.rr2    = r1_rr2;
        o_geom.deg    = r3_deg;
        o_geom.den    = r8_den;
    end
endmodule
`default_nettype wire

[src/ice_div.sv]
// Pipelined restoring divider with saturation and final subtract
`timescale 1ns / 1ps
`default_nettype none
module ice_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire logic [ice_pkg::NUM_W-1:0]  i_num,
    input  wire logic [ice_pkg::DEN_W-1:0]  i_den,
    input  wire logic [31:0]                i_rsq,
    input  wire logic                       i_deg,
    output logic                            o_vld,
    output ice_pkg::t_out                   o_res
);
    localparam int QW = ice_pkg::QUO_W;
    localparam int RW = ice_pkg::REM_W;

    logic [QW:0]    r_vld;
    logic [RW-1:0]  r_rem [0:QW];
    logic [QW-1:0]  r_low [0:QW];
    logic [QW-1:0]  r_quo [0:QW];
    logic           r_sat [0:QW];

    logic [RW-1:0]  n_rem [1:QW];
    logic [QW-1:0]  n_quo [1:QW];
    logic [RW-1:0]  w_trial [1:QW];
    logic           w_ge [1:QW];
    logic signed [49:0] w_v;
    logic           w_under;

    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            w_trial[k] = {r_rem[k-1][RW-2:0], r_low[k-1][QW-1]};
            w_ge[k]    = w_trial[k] >= {1'b0, i_den};
            n_rem[k]   = w_ge[k] ? (w_trial[k] - {1'b0, i_den}) : w_trial[k];
            n_quo[k]   = {r_quo[k-1][QW-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num[ice_pkg::NUM_W-1:QW]);
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_sat[0] <= RW'(i_num[ice_pkg::NUM_W-1:QW]) >= {1'b0, i_den};
            for (int k = 1; k <= QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= {r_low[k-1][QW-2:0], 1'b0};
                r_quo[k] <= n_quo[k];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign w_v     = $signed({18'd0, i_rsq}) - $signed({2'b00, r_quo[QW]});
    assign w_under = w_v[49] & ~(w_v[48] & w_v[47]);
    assign o_vld   = r_vld[QW];

    always_comb begin
        o_res.degenerate = i_deg;
        if (i_deg) begin
            o_res.field_value = '0;
        end else if (r_sat[QW] || w_under) begin
            o_res.field_value = {1'b1, 47'd0};
        end else begin
            o_res.field_value = w_v[47:0];
        end
    end
endmodule
`default_nettype wire

[src/implicit_cylinder_evaluator_core.sv]
// Top level: implicit cylinder function pipeline with APB configuration
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------
//  in       | i_in_valid / o_in_ready   | i_in_data  (t_in)
//  out      | o_out_valid / i_out_ready | o_out_data (t_out)
//  config   | psel penable pwrite pready| paddr pwdata prdata
//
// One beat per cycle sustained while the output buffer is not stalled; accept to result
// passes through 10 product stages, 49 divider stages and the output buffer.
// The per-step 129-bit remainder subtract sets the stage depth.
// Reset is synchronous and empties the pipeline and output buffer.
// A stall only occurs when the two-entry output buffer is full and not drained.
`timescale 1ns / 1ps
`default_nettype none
module implicit_cylinder_evaluator_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire ice_pkg::t_in               i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output ice_pkg::t_out                   o_out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ice_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ice_pkg::DATA_W-1:0] pwdata,
    output logic      [ice_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
`include "implicit_cylinder_evaluator_core_assert.svh"

    ice_pkg::t_geom w_geom;
    logic           w_en;
    logic [9:0]     r_v;

    logic signed [15:0] w_pt [0:2];
    logic signed [15:0] w_a  [0:2];
    logic signed [15:0] w_e  [0:2];
    logic signed [15:0] w_c  [0:2];
    logic signed [32:0] w_w  [0:2];

    logic signed [16:0] r1_d  [0:2];
    logic signed [16:0] r2_d  [0:2];
    logic signed [32:0] r2_da [0:2];
    logic signed [32:0] r2_de [0:2];
    logic signed [32:0] r2_cp [0:5];
    logic [32:0]        r3_cm [0:2];
    logic signed [33:0] r3_de;
    logic signed [33:0] r3_da;
    logic signed [48:0] r3_pw [0:2];
    logic [65:0]        r4_sq [0:2];
    logic signed [49:0] r4_p2;
    logic signed [66:0] r4_t1;
    logic signed [66:0] r4_t2;
    logic [67:0]        r5_cs;
    logic [65:0]        r5_m1;
    logic [48:0]        r5_m2;
    logic [67:0]        r6_cs;
    logic [65:0]        r6_ll;
    logic [65:0]        r6_lh;
    logic [65:0]        r6_hh;
    logic [49:0]        r6_qll;
    logic [48:0]        r6_qlh;
    logic [47:0]        r6_qhh;
    logic [67:0]        r7_cs;
    logic [131:0]       r7_s1;
    logic [97:0]        r7_s2;
    logic [67:0]        r8_cs;
    logic [64:0]        r8_u [0:3];
    logic [56:0]        r8_v [0:3];
    logic [67:0]        r9_cs;
    logic [163:0]       r9_t1;
    logic [129:0]       r9_t2;
    logic [ice_pkg::NUM_W-1:0] r10_num;

    logic signed [33:0] n_df [0:2];
    logic signed [67:0] n_p1;
    logic [99:0]        n_s2x;

    logic               w_dvld;
    ice_pkg::t_out      w_dres;

    ice_pkg::t_out      r_ob [0:1];
    logic               r_rd;
    logic               r_wr;
    logic [1:0]         r_cnt;
    logic               w_push;
    logic               w_pop;

    ice_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (w_geom)
    );

    assign w_en       = (r_cnt != 2'd2) | i_out_ready;
    assign o_in_ready = w_en;

    assign w_pt[0] = i_in_data.point_x;
    assign w_pt[1] = i_in_data.point_y;
    assign w_pt[2] = i_in_data.point_z;
    assign w_w[0]  = w_geom.w0;
    assign w_w[1]  = w_geom.w1;
    assign w_w[2]  = w_geom.w2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i]  = ice_pkg::half(w_geom.axis, 2'(i));
            w_e[i]  = ice_pkg::half(w_geom.ellv, 2'(i));
            w_c[i]  = ice_pkg::half(w_geom.center, 2'(i));
            n_df[i] = 34'(r2_cp[2*i]) - 34'(r2_cp[2*i+1]);
        end
        n_p1  = 68'(r4_t1) - 68'(r4_t2);
        n_s2x = 100'(r7_s2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[8:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_d[i] <= $signed({w_pt[i][15], w_pt[i]})
                         - $signed({w_c[i][15], w_c[i]});
            end

            for (int i = 0; i < 3; i++) begin
                r2_d[i]  <= r1_d[i];
                r2_da[i] <= r1_d[i] * w_a[i];
                r2_de[i] <= r1_d[i] * w_e[i];
            end
            r2_cp[0] <= r1_d[1] * w_a[2];
            r2_cp[1] <= r1_d[2] * w_a[1];
            r2_cp[2] <= r1_d[2] * w_a[0];
            r2_cp[3] <= r1_d[0] * w_a[2];
            r2_cp[4] <= r1_d[0] * w_a[1];
            r2_cp[5] <= r1_d[1] * w_a[0];

            for (int i = 0; i < 3; i++) begin
                r3_cm[i] <= n_df[i][33] ? 33'(-n_df[i]) : 33'(n_df[i]);
                r3_pw[i] <= r2_d[i] * w_w[i];
            end
            r3_de <= 34'(r2_de[0]) + 34'(r2_de[1]) + 34'(r2_de[2]);
            r3_da <= 34'(r2_da[0]) + 34'(r2_da[1]) + 34'(r2_da[2]);

            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= 66'(r3_cm[i]) * 66'(r3_cm[i]);
            end
            r4_p2 <= 50'(r3_pw[0]) + 50'(r3_pw[1]) + 50'(r3_pw[2]);
            r4_t1 <= $signed({1'b0, w_geom.a2}) * r3_de;
            r4_t2 <= w_geom.ae * r3_da;

            r5_cs <= 68'(r4_sq[0]) + 68'(r4_sq[1]) + 68'(r4_sq[2]);
            r5_m1 <= n_p1[67] ? 66'(-n_p1) : 66'(n_p1);
            r5_m2 <= r4_p2[49] ? 49'(-r4_p2) : 49'(r4_p2);

            r6_cs  <= r5_cs;
            r6_ll  <= 66'(r5_m1[32:0]) * 66'(r5_m1[32:0]);
            r6_lh  <= 66'(r5_m1[32:0]) * 66'(r5_m1[65:33]);
            r6_hh  <= 66'(r5_m1[65:33]) * 66'(r5_m1[65:33]);
            r6_qll <= 50'(r5_m2[24:0]) * 50'(r5_m2[24:0]);
            r6_qlh <= 49'(r5_m2[24:0]) * 49'(r5_m2[48:25]);
            r6_qhh <= 48'(r5_m2[48:25]) * 48'(r5_m2[48:25]);

            r7_cs <= r6_cs;
            r7_s1 <= 132'(r6_ll) + (132'(r6_lh) << 34) + (132'(r6_hh) << 66);
            r7_s2 <= 98'(r6_qll) + (98'(r6_qlh) << 26) + (98'(r6_qhh) << 50);

            r8_cs <= r7_cs;
            for (int k = 0; k < 4; k++) begin
                r8_u[k] <= 65'(r7_s1[33*k +: 33]) * 65'(w_geom.rr2);
                r8_v[k] <= 57'(n_s2x[25*k +: 25]) * 57'(w_geom.a2);
            end

            r9_cs <= r8_cs;
            r9_t1 <= 164'(r8_u[0]) + (164'(r8_u[1]) << 33)
                   + (164'(r8_u[2]) << 66) + (164'(r8_u[3]) << 99);
            r9_t2 <= 130'(r8_v[0]) + (130'(r8_v[1]) << 25)
                   + (130'(r8_v[2]) << 50) + (130'(r8_v[3]) << 75);

            r10_num <= w_geom.ellip
                     ? (ice_pkg::NUM_W'(r9_t1) + (ice_pkg::NUM_W'(r9_t2) << 28))
                     : ice_pkg::NUM_W'(r9_cs);
        end
    end

    ice_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v[9]),
        .i_num   (r10_num),
        .i_den   (w_geom.den),
        .i_rsq   (w_geom.rsq),
        .i_deg   (w_geom.deg),
        .o_vld   (w_dvld),
        .o_res   (w_dres)
    );

    // two-entry output buffer
    assign w_push      = w_dvld & w_en;
    assign w_pop       = o_out_valid & i_out_ready;
    assign o_out_valid = r_cnt != 2'd0;
    assign o_out_data  = r_ob[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ob[r_wr] <= w_dres;
        end
    end

    `ICE_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt != 2'd3, "output buffer overflow")
    `ICE_ASSERT_IMP(a_full_stall, (r_cnt == 2'd2) && !i_out_ready, !o_in_ready,
                    "input taken while output buffer full")
    `ICE_ASSERT_IMP(a_deg_zero, o_out_valid && o_out_data.degenerate,
                    o_out_data.field_value == '0, "degenerate beat with nonzero value")
    `ICE_ASSERT_NXT(a_fill, w_push && !w_pop && (r_cnt == 2'd1), r_cnt == 2'd2,
                    "output buffer count lost a beat")
endmodule
`default_nettype wire
